/* rtl/sdfp_pkg.sv */
// Types and constants shared by the status datagram field parser.
// No dependencies.
package sdfp_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_OTHER     = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_LONG      = 3'd4;

  localparam logic [4:0] F_MAGIC = 5'd0;
  localparam logic [4:0] F_TYPE  = 5'd2;
  localparam logic [4:0] F_ID    = 5'd3;
  localparam logic [4:0] F_FREQ  = 5'd4;
  localparam logic [4:0] F_MODE  = 5'd5;
  localparam logic [4:0] F_CALL  = 5'd6;
  localparam logic [4:0] F_TXEN  = 5'd9;
  localparam logic [4:0] F_TXING = 5'd10;
  localparam logic [4:0] F_DEC   = 5'd11;
  localparam logic [4:0] F_GRID  = 5'd16;
  localparam logic [4:0] F_END   = 5'd17;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  parse_status;
    logic [63:0] dial_frequency;
    logic [63:0] mode_text;
    logic [3:0]  mode_length;
    logic [63:0] grid_text;
    logic [3:0]  grid_length;
    logic [63:0] callsign_text;
    logic [3:0]  callsign_length;
    logic [1:0]  operating_state;
    logic        call_changed;
    logic        text_truncated;
  } out_item_t;

  // byte width of each fixed field, 0 for a byte array
  function automatic logic [3:0] field_size(input logic [4:0] idx);
    case (idx)
      5'd0, 5'd1, 5'd2, 5'd12, 5'd13: field_size = 4'd4;
      5'd4:                           field_size = 4'd8;
      5'd9, 5'd10, 5'd11:             field_size = 4'd1;
      default:                        field_size = 4'd0;
    endcase
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

/* rtl/sdfp_parser.sv */
// Per-byte field tracker and result builder; one byte each cycle that step is high.
// Depends on sdfp_pkg.
module sdfp_parser #(
  parameter int unsigned MAX_DATAGRAM_BYTES = 1024,
  parameter int unsigned TEXT_BYTES         = 8,
  parameter int unsigned MAX_ARRAY_BYTES    = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  sdfp_pkg::in_item_t item,
  input  logic [31:0]        magic_word,
  output logic               result_valid,
  output sdfp_pkg::out_item_t result
);

  localparam int PW = $clog2(MAX_DATAGRAM_BYTES + 2);
  localparam int AW = $clog2(MAX_ARRAY_BYTES + 1);
  localparam logic [3:0] TB = 4'(TEXT_BYTES);

  logic [4:0]    field_index;
  logic [3:0]    field_byte_count;
  logic [63:0]   word_shift;
  logic [AW-1:0] array_remaining;
  logic [PW-1:0] packet_byte_count;
  logic [63:0]   shadow_mode, shadow_grid, shadow_callsign;
  logic [3:0]    mode_len, grid_len, call_len;
  logic [2:0]    flag_bytes_seen;
  logic [2:0]    error_code;
  logic [63:0]   frequency_hold;
  logic          type_is_one, text_over;
  logic [3:0]    char_pos, call_kept;
  logic [63:0]   stored_callsign;
  logic [3:0]    stored_callsign_length;

  logic [4:0]    field_index_next;
  logic [3:0]    field_byte_count_next;
  logic [63:0]   word_shift_next;
  logic [AW-1:0] array_remaining_next;
  logic [PW-1:0] packet_byte_count_next;
  logic [63:0]   shadow_mode_next, shadow_grid_next, shadow_callsign_next;
  logic [3:0]    mode_len_next, grid_len_next, call_len_next;
  logic [2:0]    flag_bytes_seen_next, error_code_next;
  logic [63:0]   frequency_hold_next;
  logic          type_is_one_next, text_over_next;
  logic [3:0]    char_pos_next, call_kept_next;
  sdfp_pkg::out_item_t result_next;

  function automatic logic [63:0] put_char(input logic [63:0] t, input logic [3:0] pos,
                                           input logic [7:0] c);
    logic [63:0] r;
    r = t;
    if (pos < TB) r[8*(7-pos[2:0]) +: 8] = c;
    put_char = r;
  endfunction

  function automatic logic [63:0] keep_chars(input logic [63:0] t, input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) if (4'(i) < n) m[8*(7-i) +: 8] = 8'hFF;
    keep_chars = t & m;
  endfunction

  logic [3:0]  fsize;
  logic [63:0] ws;
  logic [31:0] low;
  logic [7:0]  b, cu;
  logic        finish;
  logic [3:0]  cn;
  logic [2:0]  status;
  logic [1:0]  op_st;
  logic        changed;

  always_comb begin
    b = item.data_byte;
    cu = (b >= 8'd97 && b <= 8'd122) ? b - 8'd32 : b;
    fsize = sdfp_pkg::field_size(field_index);
    ws = {word_shift[55:0], b};
    low = ws[31:0];
    finish = 1'b0;
    field_index_next = field_index;
    field_byte_count_next = field_byte_count;
    word_shift_next = word_shift;
    array_remaining_next = array_remaining;
    packet_byte_count_next = packet_byte_count;
    shadow_mode_next = shadow_mode;
    shadow_grid_next = shadow_grid;
    shadow_callsign_next = shadow_callsign;
    mode_len_next = mode_len;
    grid_len_next = grid_len;
    call_len_next = call_len;
    flag_bytes_seen_next = flag_bytes_seen;
    error_code_next = error_code;
    frequency_hold_next = frequency_hold;
    type_is_one_next = type_is_one;
    text_over_next = text_over;
    char_pos_next = char_pos;
    call_kept_next = call_kept;

    if (packet_byte_count <= PW'(MAX_DATAGRAM_BYTES))
      packet_byte_count_next = packet_byte_count + 1'b1;

    if (error_code == sdfp_pkg::ST_OK && field_index < sdfp_pkg::F_END) begin
      if (fsize == 4'd0 && array_remaining != '0) begin
        if (field_index == sdfp_pkg::F_MODE) begin
          shadow_mode_next = put_char(shadow_mode, char_pos, b);
          if (char_pos < TB) char_pos_next = char_pos + 1'b1;
        end else if (field_index == sdfp_pkg::F_GRID) begin
          shadow_grid_next = put_char(shadow_grid, char_pos, b);
          if (char_pos < TB) char_pos_next = char_pos + 1'b1;
        end else if (field_index == sdfp_pkg::F_CALL) begin
          if (!(char_pos == 4'd0 && call_kept == 4'd0 && sdfp_pkg::is_blank(b))) begin
            shadow_callsign_next = put_char(shadow_callsign, char_pos, cu);
            // position saturates one past the stored width: enough for the length test
            if (char_pos <= TB) char_pos_next = char_pos + 1'b1;
            if (!sdfp_pkg::is_blank(b)) call_kept_next = char_pos_next;
          end
        end
        array_remaining_next = array_remaining - 1'b1;
        if (array_remaining == AW'(1)) finish = 1'b1;
      end else begin
        word_shift_next = ws;
        field_byte_count_next = field_byte_count + 1'b1;
        if (fsize != 4'd0) begin
          if (field_byte_count + 1'b1 >= fsize) begin
            case (field_index)
              sdfp_pkg::F_MAGIC: if (low != magic_word) error_code_next = sdfp_pkg::ST_BAD_MAGIC;
              sdfp_pkg::F_TYPE:  type_is_one_next = (low == 32'd1);
              sdfp_pkg::F_FREQ:  frequency_hold_next = ws;
              sdfp_pkg::F_TXEN:  if (low != 0) flag_bytes_seen_next[0] = 1'b1;
              sdfp_pkg::F_TXING: if (low != 0) flag_bytes_seen_next[1] = 1'b1;
              sdfp_pkg::F_DEC:   if (low != 0) flag_bytes_seen_next[2] = 1'b1;
              default: ;
            endcase
            if (error_code_next == sdfp_pkg::ST_OK) finish = 1'b1;
          end
        end else if (field_byte_count + 1'b1 >= 4'd4) begin
          if (low == 32'hFFFF_FFFF || low == 32'd0) finish = 1'b1;
          else if (low > 32'(MAX_ARRAY_BYTES)) error_code_next = sdfp_pkg::ST_LONG;
          else begin
            if (field_index == sdfp_pkg::F_MODE) begin
              mode_len_next = (low > 32'(TEXT_BYTES)) ? TB : low[3:0];
              if (low > 32'(TEXT_BYTES)) text_over_next = 1'b1;
            end else if (field_index == sdfp_pkg::F_GRID) begin
              grid_len_next = (low > 32'(TEXT_BYTES)) ? TB : low[3:0];
              if (low > 32'(TEXT_BYTES)) text_over_next = 1'b1;
            end
            array_remaining_next = low[AW-1:0];
          end
        end
      end
    end

    cn = (call_kept_next > TB) ? TB : call_kept_next;
    if (finish) begin
      if (field_index == sdfp_pkg::F_CALL) begin
        if (call_kept_next > TB) text_over_next = 1'b1;
        shadow_callsign_next = keep_chars(shadow_callsign_next, cn);
        call_len_next = cn;
      end
      if (field_index == sdfp_pkg::F_ID && !type_is_one)
        error_code_next = sdfp_pkg::ST_OTHER;
      field_index_next = field_index + 1'b1;
      field_byte_count_next = '0;
      word_shift_next = '0;
      array_remaining_next = '0;
      char_pos_next = '0;
    end

    if (packet_byte_count_next > PW'(MAX_DATAGRAM_BYTES)) status = sdfp_pkg::ST_LONG;
    else if (error_code_next != sdfp_pkg::ST_OK) status = error_code_next;
    else if (field_index_next < sdfp_pkg::F_END) status = sdfp_pkg::ST_SHORT;
    else status = sdfp_pkg::ST_OK;

    changed = call_len_next != 4'd0 && (call_len_next != stored_callsign_length ||
              shadow_callsign_next != stored_callsign);
    if (flag_bytes_seen_next[1]) op_st = 2'd3;
    else if (flag_bytes_seen_next[0]) op_st = 2'd2;
    else if (flag_bytes_seen_next[2]) op_st = 2'd1;
    else op_st = 2'd0;

    result_next = '0;
    result_next.parse_status = status;
    if (status == sdfp_pkg::ST_OK) begin
      result_next.dial_frequency  = frequency_hold_next;
      result_next.mode_text       = shadow_mode_next;
      result_next.mode_length     = mode_len_next;
      result_next.grid_text       = shadow_grid_next;
      result_next.grid_length     = grid_len_next;
      result_next.callsign_text   = shadow_callsign_next;
      result_next.callsign_length = call_len_next;
      result_next.operating_state = op_st;
      result_next.call_changed    = changed;
      result_next.text_truncated  = text_over_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      field_index <= '0; field_byte_count <= '0; word_shift <= '0;
      array_remaining <= '0; packet_byte_count <= '0;
      shadow_mode <= '0; shadow_grid <= '0; shadow_callsign <= '0;
      mode_len <= '0; grid_len <= '0; call_len <= '0;
      flag_bytes_seen <= '0; error_code <= '0; frequency_hold <= '0;
      type_is_one <= 1'b0; text_over <= 1'b0; char_pos <= '0; call_kept <= '0;
    end else if (step) begin
      field_index <= field_index_next; field_byte_count <= field_byte_count_next;
      word_shift <= word_shift_next; array_remaining <= array_remaining_next;
      packet_byte_count <= packet_byte_count_next;
      shadow_mode <= shadow_mode_next; shadow_grid <= shadow_grid_next;
      shadow_callsign <= shadow_callsign_next;
      mode_len <= mode_len_next; grid_len <= grid_len_next; call_len <= call_len_next;
      flag_bytes_seen <= flag_bytes_seen_next; error_code <= error_code_next;
      frequency_hold <= frequency_hold_next; type_is_one <= type_is_one_next;
      text_over <= text_over_next; char_pos <= char_pos_next;
      call_kept <= call_kept_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_callsign <= '0;
      stored_callsign_length <= '0;
    end else if (step && item.last_byte && status == sdfp_pkg::ST_OK && changed) begin
      stored_callsign <= shadow_callsign_next;
      stored_callsign_length <= call_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= step && item.last_byte;
  end

  always_ff @(posedge clk) begin
    if (step && item.last_byte) result <= result_next;
  end

endmodule

/* rtl/sdfp_out_skid.sv */
// Two-entry output buffer decoupling results from downstream stalls.
// Depends on sdfp_pkg.
module sdfp_out_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sdfp_pkg::out_item_t push_data,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output sdfp_pkg::out_item_t out_data
);

  sdfp_pkg::out_item_t main_q, spare_q;
  logic main_v, spare_v;

  // room is kept whenever a pending result can still be absorbed
  assign room = !spare_v;
  assign out_valid = main_v;
  assign out_data = main_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      spare_v <= 1'b0;
    end else begin
      if (!main_v || out_ready) begin
        main_v <= spare_v || push;
        spare_v <= spare_v && push;
      end else if (push) begin
        spare_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v || out_ready) begin
      if (spare_v) begin
        main_q <= spare_q;
        if (push) spare_q <= push_data;
      end else if (push) main_q <= push_data;
    end else if (push) spare_q <= push_data;
  end

endmodule

/* rtl/status_datagram_field_parser_unit.sv */
// Channel   | Dir | Handshake               | Payload
// in        | in  | in_valid / in_ready     | sdfp_pkg::in_item_t
// out       | out | out_valid / out_ready   | sdfp_pkg::out_item_t
// cfg       | in  | cfg_valid / cfg_ready   | magic word, 32 bits
// One byte is taken every cycle unless input stalls; after its last byte transfer
// a datagram's result is offered via the field tracker's result register, then the
// output buffer. Input stalls while both buffer entries hold untaken results,
// and in a cycle where a result arrives while the output entry is held.
// Synchronous reset restores the magic word and clears the stored callsign.
// Depends on sdfp_pkg, sdfp_parser, sdfp_out_skid.
module status_datagram_field_parser_unit #(
  parameter int unsigned MAX_DATAGRAM_BYTES = 1024,
  parameter int unsigned TEXT_BYTES         = 8,
  parameter int unsigned MAX_ARRAY_BYTES    = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdfp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sdfp_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  logic [31:0] magic_word;
  logic step, res_v, room;
  sdfp_pkg::out_item_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) magic_word <= 32'hADBC_CBDA;
    else if (cfg_valid) magic_word <= cfg_data;
  end

  // a result in flight needs a spare entry: hold off while it arrives and the output entry is held
  assign in_ready = room && !(res_v && out_valid && !out_ready);
  assign step = in_valid && in_ready;

  sdfp_parser #(
    .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES),
    .TEXT_BYTES(TEXT_BYTES),
    .MAX_ARRAY_BYTES(MAX_ARRAY_BYTES)
  ) u_parser (
    .clk, .rst, .step, .item(in_data), .magic_word,
    .result_valid(res_v), .result(res)
  );

  sdfp_out_skid u_skid (
    .clk, .rst, .push(res_v), .push_data(res), .room,
    .out_valid, .out_ready, .out_data
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_v |-> room) else $error("result pushed into full buffer");
  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    step && in_data.last_byte |=> res_v) else $error("missing result");
  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.parse_status != sdfp_pkg::ST_OK |->
    out_data.dial_frequency == 64'd0 && !out_data.call_changed)
    else $error("rejected datagram carries fields");
`endif

endmodule
